/* rtl/iqfc_pkg.sv */
// Shared types and constants for the IQ sample format converter.
// No dependencies; imported by the lane, merge and top-level modules.
`default_nettype none
package iqfc_pkg;

  typedef enum logic [2:0] {
    FMT_CF32 = 3'd0,
    FMT_CF64 = 3'd1,
    FMT_CI32 = 3'd2,
    FMT_CI16 = 3'd3,
    FMT_CI8  = 3'd4
  } iqfc_fmt_t;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_CLIP_EN = 1'b1
  } iqfc_reg_t;

  localparam logic [30:0] ABS_INF = 31'h7F800000;
  localparam logic [30:0] ABS_ONE = 31'h3F800000;

  // what one lane reports to the merge stage
  typedef struct packed {
    logic [30:0] abs_bits;
    logic        is_nan;
    logic        over_one;
  } iqfc_lane_info_t;

  function automatic logic fmt_is_int(input logic [2:0] fmt);
    return (fmt != FMT_CF32) && (fmt != FMT_CF64);
  endfunction

endpackage
`default_nettype wire

/* rtl/iqfc_lane.sv */
// One conversion lane: float32 bits to cf32, cf64 or clamped integer word.
// Depends on iqfc_pkg.
`default_nettype none
module iqfc_lane (
  input  wire logic [31:0]              bits,
  input  wire logic [2:0]               fmt,
  output logic [63:0]                   word,
  output iqfc_pkg::iqfc_lane_info_t     info
);
  import iqfc_pkg::*;

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] man;
  logic        nan;
  logic        over;
  logic [63:0] wide;
  logic [4:0]  top_pos;
  logic [4:0]  nshift;
  logic [22:0] man_norm;
  logic [4:0]  k;
  logic [23:0] m24;
  logic [54:0] prod;
  logic [55:0] rnd;
  logic [7:0]  s;
  logic [55:0] q;
  logic [31:0] full;
  logic [31:0] mag;
  logic [63:0] sval;
  logic [63:0] mask;

  assign sgn  = bits[31];
  assign ex   = bits[30:23];
  assign man  = bits[22:0];
  assign nan  = (bits[30:0] > ABS_INF);
  assign over = !nan && (bits[30:0] > ABS_ONE);

  assign info.abs_bits = bits[30:0];
  assign info.is_nan   = nan;
  assign info.over_one = over;

  // cf64 widening; subnormals normalized by leading-one position
  always_comb begin
    top_pos = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (man[i]) top_pos = 5'(i);
    end
    nshift   = 5'd23 - top_pos;
    man_norm = man << nshift;
    if (ex == 8'hFF) begin
      if (man == 23'd0) wide = {sgn, 11'h7FF, 52'd0};
      else wide = {sgn, 11'h7FF, 1'b1, man[21:0], 29'd0};
    end else if (ex == 8'd0) begin
      if (man == 23'd0) wide = {sgn, 63'd0};
      else wide = {sgn, 11'd897 - {6'd0, nshift}, man_norm, 29'd0};
    end else begin
      wide = {sgn, {3'd0, ex} + 11'd896, man, 29'd0};
    end
  end

  // integer quantize: m*(2^k-1), round to 53 bits, truncate
  always_comb begin
    case (fmt)
      FMT_CI32: k = 5'd31;
      FMT_CI16: k = 5'd15;
      default:  k = 5'd7;
    endcase
    m24  = {ex != 8'd0, man};
    prod = ({31'd0, m24} << k) - {31'd0, m24};
    if (prod[54]) begin
      rnd = {1'b0, prod[54:2] + 53'((prod[1] && (prod[0] || prod[2]))), 2'b00};
    end else if (prod[53]) begin
      rnd = {1'b0, 1'b0, prod[53:1] + 53'((prod[0] && prod[1])), 1'b0};
    end else begin
      rnd = {1'b0, prod};
    end
    s    = (ex == 8'd0) ? 8'd149 : 8'd150 - ex;
    q    = rnd >> s;
    full = (32'd1 << k) - 32'd1;
    if (nan) mag = 32'd0;
    else if (over) mag = full;
    else mag = q[31:0];
    sval = sgn ? (64'd0 - {32'd0, mag}) : {32'd0, mag};
    mask = (64'd1 << ({1'b0, k} + 6'd1)) - 64'd1;
  end

  always_comb begin
    case (fmt)
      FMT_CF32: word = {32'd0, bits};
      FMT_CF64: word = wide;
      default:  word = sval & mask;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/iqfc_merge.sv */
// Merge stage: running peak of both lanes and saturating counters.
// Depends on iqfc_pkg.
`default_nettype none
module iqfc_merge #(
  parameter int COUNT_WIDTH = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        update,
  input  wire logic                        clip_en,
  input  wire iqfc_pkg::iqfc_lane_info_t   info_re,
  input  wire iqfc_pkg::iqfc_lane_info_t   info_im,
  output logic [30:0]                      peak_next,
  output logic [COUNT_WIDTH-1:0]           clip_next,
  output logic [COUNT_WIDTH-1:0]           comp_next
);
  import iqfc_pkg::*;

  logic [30:0]            peak;
  logic [COUNT_WIDTH-1:0] clip_cnt;
  logic [COUNT_WIDTH-1:0] comp_cnt;
  logic [30:0]            cand;
  logic [1:0]             clip_inc;
  logic [COUNT_WIDTH:0]   clip_sum;
  logic [COUNT_WIDTH:0]   comp_sum;

  // *_next is the value after this beat; it holds when update is low
  always_comb begin
    // NaN on either side picks Q
    cand = (!info_re.is_nan && !info_im.is_nan && info_re.abs_bits > info_im.abs_bits)
           ? info_re.abs_bits : info_im.abs_bits;
    peak_next = (update && cand <= ABS_INF && cand > peak) ? cand : peak;
    comp_sum  = {1'b0, comp_cnt} + (COUNT_WIDTH+1)'(2);
    if (!update) comp_next = comp_cnt;
    else comp_next = comp_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : comp_sum[COUNT_WIDTH-1:0];
    clip_inc  = {1'b0, info_re.over_one} + {1'b0, info_im.over_one};
    clip_sum  = {1'b0, clip_cnt} + (COUNT_WIDTH+1)'(clip_inc);
    if (!update || !clip_en) clip_next = clip_cnt;
    else clip_next = clip_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : clip_sum[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak     <= '0;
      clip_cnt <= '0;
      comp_cnt <= '0;
    end else if (update) begin
      peak     <= peak_next;
      clip_cnt <= clip_next;
      comp_cnt <= comp_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/iq_sample_format_converter_core.sv */
// Top level of the IQ sample format converter: two conversion lanes,
// one merge stage and the output register. Depends on iqfc_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one complex sample a beat,
//    I and Q as float32 bits plus block_end.
//  - Output channel (out_valid / out_stall) carries the converted words,
//    the block_end copy, running peak and both counters after that sample.
//  - Config: cfg_write with cfg_index 0 sets output_format, 1 sets
//    clip_count_enable. Write only while no beats are in flight.
//  - An accepted input beat is registered directly into the output register.
//  - Throughput: one sample per clock unless stalled; the two lanes and
//    merge next-value logic are combinational ahead of the output register.
//  - in_stall is high only while the output register holds a beat that
//    the receiver stalls; a new beat enters in the cycle the old one leaves.
//  - Reset clears config, peak, counters and output valid.
//  - Peak and counters move only on integer formats (ci32/ci16/ci8;
//    codes five to seven act as ci8).
`default_nettype none
module iq_sample_format_converter_core #(
  parameter int COUNT_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_real_bits,
  input  wire logic [31:0] in_imag_bits,
  input  wire logic        block_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_real,
  output logic [63:0]      out_imag,
  output logic             out_block_end,
  output logic [30:0]      peak_bits,
  output logic [47:0]      clipped_count,
  output logic [47:0]      component_count
);
  import iqfc_pkg::*;

  logic [2:0]             output_format;
  logic                   clip_count_enable;
  logic                   in_take;
  logic                   track;
  logic [63:0]            word_re;
  logic [63:0]            word_im;
  iqfc_lane_info_t        info_re;
  iqfc_lane_info_t        info_im;
  logic [30:0]            peak_next;
  logic [COUNT_WIDTH-1:0] clip_next;
  logic [COUNT_WIDTH-1:0] comp_next;
  logic [63:0]            clip_ext;
  logic [63:0]            comp_ext;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_format     <= FMT_CF32;
      clip_count_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT:  output_format     <= cfg_data;
        REG_CLIP_EN: clip_count_enable <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign track    = in_take && fmt_is_int(output_format);

  iqfc_lane u_lane_re (
    .bits (in_real_bits),
    .fmt  (output_format),
    .word (word_re),
    .info (info_re)
  );

  iqfc_lane u_lane_im (
    .bits (in_imag_bits),
    .fmt  (output_format),
    .word (word_im),
    .info (info_im)
  );

  iqfc_merge #(.COUNT_WIDTH(COUNT_WIDTH)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .update    (track),
    .clip_en   (clip_count_enable),
    .info_re   (info_re),
    .info_im   (info_im),
    .peak_next (peak_next),
    .clip_next (clip_next),
    .comp_next (comp_next)
  );

  // counters shown masked to 48 bits
  assign clip_ext = 64'(clip_next);
  assign comp_ext = 64'(comp_next);

  // output register; on float formats merge holds, so *_next = current
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_real        <= word_re;
      out_imag        <= word_im;
      out_block_end   <= block_end;
      peak_bits       <= peak_next;
      clipped_count   <= clip_ext[47:0];
      component_count <= comp_ext[47:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/iqfc_checker.sv */
// Port-level checks for the IQ sample format converter, bound to the top.
// Depends on iq_sample_format_converter_core ports only.
`default_nettype none
module iqfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_real,
  input wire logic [30:0] peak_bits
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_real))
    else $error("stalled output beat changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");

  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat did not reach output");

  a_peak_not_nan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_bits <= 31'h7F800000)
    else $error("peak holds a NaN");

endmodule

bind iq_sample_format_converter_core iqfc_checker u_iqfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_real  (out_real),
  .peak_bits (peak_bits)
);
`default_nettype wire

/* test/iq_sample_format_converter_core_test.sv */
// Self-checking testbench for iq_sample_format_converter_core: float32 I/Q
// beats are converted by a local predictor and compared with every output beat.
// Depends on iqfc_pkg and the core RTL.
`timescale 1ns / 100ps
module iq_sample_format_converter_core_test;
  import iqfc_pkg::*;

  localparam logic [2:0] FMT_UNDEF_LO = 3'd5;  // codes 5..7 behave as ci8
  localparam logic [2:0] FMT_UNDEF_HI = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [47:0] COUNT_MAX = {48{1'b1}};

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
    logic        be;
    logic [30:0] peak;
    logic [47:0] clip;
    logic [47:0] comp;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [2:0]  cfg_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_real_bits = 32'd0;
  logic [31:0] in_imag_bits = 32'd0;
  logic        block_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_real;
  logic [63:0] out_imag;
  logic        out_block_end;
  logic [30:0] peak_bits;
  logic [47:0] clipped_count;
  logic [47:0] component_count;

  iq_sample_format_converter_core dut (.*);

  // predictor state, mirrors of config and tracking registers
  logic [2:0]  fmt_mirror = FMT_CF32;
  logic        clip_en_mirror = 1'b0;
  logic [30:0] peak_state = '0;
  logic [47:0] clip_state = '0;
  logic [47:0] comp_state = '0;

  conv_result_t pending_results[$];
  int  error_count = 0;
  bit  quiet = 1'b0;        // no idling on either side while set
  int  hold_cycles = 0;     // receiver hold-off request
  int  idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // float helpers
  // ---------------------------------------------------------------------
  function automatic bit is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  // exact float32 -> float64 bit widening; NaN gets quiet bit set
  function automatic logic [63:0] widen_bits(input logic [31:0] b);
    logic [63:0] sgn;
    logic [22:0] man;
    int          e;
    sgn = {b[31], 63'd0};
    man = b[22:0];
    if (b[30:23] == 8'hFF) begin
      if (man == 0) return sgn | {1'b0, 11'h7FF, 52'd0};
      return sgn | {1'b0, 11'h7FF, man, 29'd0} | (64'd1 << 51);
    end
    if (b[30:23] == 8'd0) begin
      if (man == 0) return sgn;
      e = 1;
      while (man[22] == 1'b0) begin
        man = man << 1;
        e--;
      end
      man = man << 1;  // drop the hidden one
      e--;
      return sgn | {1'b0, 11'(e - 127 + 1023), man, 29'd0};
    end
    return sgn | {1'b0, 11'(int'(b[30:23]) - 127 + 1023), man, 29'd0};
  endfunction

  function automatic logic [63:0] quantize_part(input logic [31:0] b, input logic [2:0] fmt);
    real         r;
    real         scale;
    logic [63:0] mask;
    integer      q;
    if (is_nan(b)) return 64'd0;
    case (fmt)
      FMT_CI32: begin scale = 2147483647.0; mask = 64'hFFFF_FFFF; end
      FMT_CI16: begin scale = 32767.0; mask = 64'hFFFF; end
      default:  begin scale = 127.0; mask = 64'hFF; end
    endcase
    r = $bitstoreal(widen_bits(b));
    if (r > 1.0) r = 1.0;
    if (r < -1.0) r = -1.0;
    q = $rtoi(r * scale);
    return 64'(longint'(q)) & mask;
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] c, input logic [47:0] inc);
    if (inc > COUNT_MAX - c) return COUNT_MAX;
    return c + inc;
  endfunction

  // convert one sample and advance the tracking state
  function automatic conv_result_t convert_sample(input logic [31:0] rb, input logic [31:0] ib,
                                                  input logic be);
    conv_result_t res;
    logic [30:0]  ar;
    logic [30:0]  ai;
    logic [30:0]  mb;
    bit           nan_r;
    bit           nan_i;
    ar = rb[30:0];
    ai = ib[30:0];
    nan_r = is_nan(rb);
    nan_i = is_nan(ib);
    if (fmt_mirror == FMT_CF32) begin
      res.re = {32'd0, rb};
      res.im = {32'd0, ib};
    end else if (fmt_mirror == FMT_CF64) begin
      res.re = widen_bits(rb);
      res.im = widen_bits(ib);
    end else begin
      // NaN on either side makes |Q| the peak candidate
      mb = (!nan_r && !nan_i && ar > ai) ? ar : ai;
      if (!is_nan({1'b0, mb}) && mb > peak_state) peak_state = mb;
      comp_state = sat_add(comp_state, 48'd2);
      if (clip_en_mirror)
        clip_state = sat_add(clip_state, 48'(!nan_r && ar > ABS_ONE) +
                                         48'(!nan_i && ai > ABS_ONE));
      res.re = quantize_part(rb, fmt_mirror);
      res.im = quantize_part(ib, fmt_mirror);
    end
    res.be = be;
    res.peak = peak_state;
    res.clip = clip_state;
    res.comp = comp_state;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // input monitor: predict on every accepted input beat
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      pending_results.push_back(convert_sample(in_real_bits, in_imag_bits, block_end));
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t: %s got %h expected %h", $time, what, got, exp_val);
    error_count++;
  endtask

  // output checker: oldest expectation against each accepted output beat
  always @(posedge clk) begin
    conv_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", out_real, 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_real !== e.re) report_mismatch("out_real", out_real, e.re);
        if (out_imag !== e.im) report_mismatch("out_imag", out_imag, e.im);
        if (out_block_end !== e.be) report_mismatch("out_block_end", 64'(out_block_end), 64'(e.be));
        if (peak_bits !== e.peak) report_mismatch("peak_bits", 64'(peak_bits), 64'(e.peak));
        if (clipped_count !== e.clip)
          report_mismatch("clipped_count", 64'(clipped_count), 64'(e.clip));
        if (component_count !== e.comp)
          report_mismatch("component_count", 64'(component_count), 64'(e.comp));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 29);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("iq_sample_format_converter_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [31:0] rb, input logic [31:0] ib, input logic be);
    if (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_real_bits <= rb;
    in_imag_bits <= ib;
    block_end <= be;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input iqfc_reg_t idx, input logic [2:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FORMAT) fmt_mirror = val;
    else clip_en_mirror = val[0];
  endtask

  function automatic logic [31:0] special_value(input int k);
    case (k % 16)
      0:  return 32'h0000_0000;  // +0
      1:  return 32'h8000_0000;  // -0
      2:  return 32'h3F80_0000;  // +1
      3:  return 32'hBF80_0000;  // -1
      4:  return 32'h3F80_0001;  // just above one
      5:  return 32'h7F80_0000;  // +inf
      6:  return 32'hFF80_0000;  // -inf
      7:  return 32'h7FC0_0000;  // quiet NaN
      8:  return 32'h7F80_0001;  // signaling NaN
      9:  return 32'hFFFF_FFFF;  // negative NaN, full payload
      10: return 32'h0000_0001;  // smallest subnormal
      11: return 32'h807F_FFFF;  // largest negative subnormal
      12: return 32'h7F7F_FFFF;  // max finite
      13: return 32'h3F7F_FFFF;  // just below one
      14: return 32'hBF00_0000;  // -0.5
      default: return 32'h3EFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return special_value($urandom_range(15));
    // magnitudes near one, where rounding and clamping matter
    if (pick < 60) return {1'($urandom), 8'($urandom_range(120, 128)), 23'($urandom)};
    return $urandom;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_sample(random_value(), random_value(), ($urandom_range(7) == 0));
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed_specials();
    int k = 0;
    write_reg(REG_CLIP_EN, 3'd1);
    for (int f = 0; f < 8; f++) begin
      write_reg(REG_FORMAT, 3'(f));
      repeat (3) begin
        send_sample(special_value(k), special_value(k + 5), k[0]);
        k++;
      end
    end
  endtask

  task automatic test_random_settings();
    logic [2:0] fmts[8] = '{FMT_CI32, FMT_CF32, FMT_CI16, FMT_CF64, FMT_CI8,
                            FMT_UNDEF_LO, FMT_UNDEF_HI, FMT_CI32};
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_FORMAT, fmts[s]);
      write_reg(REG_CLIP_EN, 3'(s % 2));
      send_random(90);
    end
  endtask

  task automatic test_no_idle_stretch();
    write_reg(REG_FORMAT, FMT_CI16);
    write_reg(REG_CLIP_EN, 3'd1);
    quiet = 1'b1;
    send_random(100);
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    write_reg(REG_FORMAT, FMT_CI8);
    hold_cycles = 200;
    send_random(30);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_specials();
    test_random_settings();
    test_no_idle_stretch();
    test_backpressure();
    wait_drained();
    repeat (5) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("iq_sample_format_converter_core: match");
    end else begin
      $display("iq_sample_format_converter_core: mismatch");
    end
    $finish;
  end

endmodule
